[design/ods_pkg.sv]
// ----------------------------------------------------------------------------
// ods_pkg: shared types and constants of the obstacle detour sequencer
// Holds the phase encoding, command codes, register indexes and the result
// word layout.
// ----------------------------------------------------------------------------
package ods_pkg;

  // Detour phases, one-hot.
  typedef enum logic [7:0] {
    PH_IDLE   = 8'b0000_0001,
    PH_PAUSE  = 8'b0000_0010,
    PH_PROBE  = 8'b0000_0100,
    PH_AWAY   = 8'b0000_1000,
    PH_DIAG   = 8'b0001_0000,
    PH_PTURN  = 8'b0010_0000,
    PH_PADV   = 8'b0100_0000,
    PH_RETURN = 8'b1000_0000
  } phase_t;

  // Binary phase numbers as reported on the result item.
  localparam logic [2:0] PN_IDLE   = 3'd0;
  localparam logic [2:0] PN_PAUSE  = 3'd1;
  localparam logic [2:0] PN_PROBE  = 3'd2;
  localparam logic [2:0] PN_AWAY   = 3'd3;
  localparam logic [2:0] PN_DIAG   = 3'd4;
  localparam logic [2:0] PN_PTURN  = 3'd5;
  localparam logic [2:0] PN_PADV   = 3'd6;
  localparam logic [2:0] PN_RETURN = 3'd7;

  // Maneuver command codes.
  localparam logic [1:0] MAN_NONE  = 2'd0;
  localparam logic [1:0] MAN_BEGIN = 2'd1;
  localparam logic [1:0] MAN_END   = 2'd2;

  // Turn command codes.
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_LEFT  = 2'd1;
  localparam logic [1:0] TURN_RIGHT = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_PAUSE_MS     = 3'd0;
  localparam logic [2:0] REG_AWAY_ANGLE   = 3'd1;
  localparam logic [2:0] REG_RETURN_ANGLE = 3'd2;
  localparam logic [2:0] REG_MAX_TRIES    = 3'd3;
  localparam logic [2:0] REG_DIAGONAL_MM  = 3'd4;
  localparam logic [2:0] REG_ALONGSIDE_MM = 3'd5;

  localparam logic [11:0] ANGLE_MAX = 12'hFFF;

  // One command word, halt in the lowest bit.
  typedef struct packed {
    logic        abandoned;
    logic [2:0]  phase_now;
    logic [15:0] advance_mm;
    logic [11:0] turn_deg;
    logic [1:0]  turn_cmd;
    logic        start_probe;
    logic [1:0]  maneuver_cmd;
    logic        halt;
  } result_t;

  // Binary number of a one-hot phase.
  function automatic logic [2:0] phase_num(phase_t p);
    logic [2:0] n;
    unique case (p)
      PH_IDLE:   n = PN_IDLE;
      PH_PAUSE:  n = PN_PAUSE;
      PH_PROBE:  n = PN_PROBE;
      PH_AWAY:   n = PN_AWAY;
      PH_DIAG:   n = PN_DIAG;
      PH_PTURN:  n = PN_PTURN;
      PH_PADV:   n = PN_PADV;
      PH_RETURN: n = PN_RETURN;
      default:   n = PN_IDLE;
    endcase
    return n;
  endfunction

endpackage

[design/obstacle_detour_sequencer_core.sv]
// ----------------------------------------------------------------------------
// obstacle_detour_sequencer_core: detour phase sequencer
// Takes one update tick per item and emits one command word per tick while
// stepping through pause, probe, turn and advance phases around an obstacle.
// ----------------------------------------------------------------------------
// The command word for a tick is registered and appears in the cycle after the tick is taken.
// Throughput: one tick per cycle while the output is not stalled; the phase logic
// is combinational between the state registers and the result register.
// Reset (rst, synchronous): phase idle, counters and latches cleared, the
// configuration registers return to their defaults, no result pending.
module obstacle_detour_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] now_ms, [32] autonomous_mode, [33] obstacle_blocking,
  // [34] motion_busy, [35] probe_busy, [36] clearest_side, [37] veto_active
  input  logic [39:0] s_tdata,
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] halt, [2:1] maneuver_cmd, [3] start_probe, [5:4] turn_cmd,
  // [17:6] turn_deg, [33:18] advance_mm, [36:34] phase_now, [37] abandoned
  output logic [39:0] m_tdata,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ods_pkg::*;

  // Configuration registers.
  logic [15:0] pause_ms;
  logic [7:0]  away_angle_deg;
  logic [7:0]  return_angle_deg;
  logic [3:0]  max_tries;
  logic [15:0] diagonal_mm;
  logic [15:0] alongside_mm;

  // Sequencer state.
  phase_t      phase, phase_next;
  phase_t      next_phase, next_phase_next;
  logic [31:0] pause_start, pause_start_next;
  logic        side_right, side_right_next;
  logic [11:0] angle_sum, angle_sum_next;
  logic [3:0]  try_count, try_count_next;
  logic        gave_up, gave_up_next;

  // Result register.
  result_t     res, res_next;
  logic        res_valid;

  // Input fields.
  logic [31:0] now_ms;
  logic        autonomous_mode, obstacle_blocking, motion_busy;
  logic        probe_busy, clearest_side, veto_active;
  logic        s_acc;

  logic [31:0] elapsed;
  logic        pause_running;
  logic [12:0] angle_wide;
  logic [11:0] angle_sat;
  logic [3:0]  try_inc;

  assign now_ms            = s_tdata[31:0];
  assign autonomous_mode   = s_tdata[32];
  assign obstacle_blocking = s_tdata[33];
  assign motion_busy       = s_tdata[34];
  assign probe_busy        = s_tdata[35];
  assign clearest_side     = s_tdata[36];
  assign veto_active       = s_tdata[37];

  // Take a new item whenever the result slot is free or being emptied.
  assign s_tready = !res_valid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = res_valid;
  assign m_tdata  = {2'b00, res};

  // Pause timer and angle accumulator arithmetic.
  assign elapsed       = now_ms - pause_start;
  assign pause_running = elapsed < {16'd0, pause_ms};
  assign angle_wide    = {1'b0, angle_sum} + {5'd0, away_angle_deg};
  assign angle_sat     = angle_wide[12] ? ANGLE_MAX : angle_wide[11:0];
  assign try_inc       = try_count + 4'd1;

  // Phase step for one tick.
  always_comb begin
    phase_next       = phase;
    next_phase_next  = next_phase;
    pause_start_next = pause_start;
    side_right_next  = side_right;
    angle_sum_next   = angle_sum;
    try_count_next   = try_count;
    gave_up_next     = gave_up;
    res_next         = '0;

    unique case (phase)
      PH_IDLE: begin
        if (autonomous_mode) begin
          if (!obstacle_blocking) begin
            gave_up_next = 1'b0;
          end else if (!gave_up && !motion_busy) begin
            res_next.maneuver_cmd = MAN_BEGIN;
            res_next.halt         = 1'b1;
            angle_sum_next        = '0;
            try_count_next        = '0;
            next_phase_next       = PH_PROBE;
            pause_start_next      = now_ms;
            phase_next            = PH_PAUSE;
          end
        end
      end
      PH_PAUSE: begin
        if (!pause_running) begin
          phase_next = next_phase;
          unique case (next_phase)
            PH_PROBE: res_next.start_probe = 1'b1;
            PH_AWAY: begin
              res_next.turn_cmd = side_right ? TURN_RIGHT : TURN_LEFT;
              res_next.turn_deg = {4'd0, away_angle_deg};
              angle_sum_next    = angle_sat;
            end
            PH_DIAG:  res_next.advance_mm = diagonal_mm;
            PH_PTURN: begin
              res_next.turn_cmd = side_right ? TURN_LEFT : TURN_RIGHT;
              res_next.turn_deg = angle_sum;
            end
            PH_PADV:  res_next.advance_mm = alongside_mm;
            PH_RETURN: begin
              res_next.turn_cmd = side_right ? TURN_LEFT : TURN_RIGHT;
              res_next.turn_deg = {4'd0, return_angle_deg};
            end
            default: ;
          endcase
        end
      end
      PH_PROBE: begin
        if (!probe_busy) begin
          side_right_next  = clearest_side;
          res_next.halt    = 1'b1;
          next_phase_next  = PH_AWAY;
          pause_start_next = now_ms;
          phase_next       = PH_PAUSE;
        end
      end
      PH_AWAY: begin
        if (!motion_busy) begin
          if (veto_active) begin
            try_count_next = try_inc;
            if (try_inc < max_tries) begin
              res_next.halt    = 1'b1;
              next_phase_next  = PH_AWAY;
              pause_start_next = now_ms;
              phase_next       = PH_PAUSE;
            end else begin
              gave_up_next          = 1'b1;
              res_next.halt         = 1'b1;
              res_next.maneuver_cmd = MAN_END;
              phase_next            = PH_IDLE;
            end
          end else begin
            res_next.halt    = 1'b1;
            next_phase_next  = PH_DIAG;
            pause_start_next = now_ms;
            phase_next       = PH_PAUSE;
          end
        end
      end
      PH_DIAG, PH_PTURN, PH_PADV: begin
        if (!motion_busy) begin
          res_next.halt    = 1'b1;
          pause_start_next = now_ms;
          phase_next       = PH_PAUSE;
          unique case (phase)
            PH_DIAG:  next_phase_next = PH_PTURN;
            PH_PTURN: next_phase_next = PH_PADV;
            default:  next_phase_next = PH_RETURN;
          endcase
        end
      end
      PH_RETURN: begin
        if (!motion_busy) begin
          res_next.halt         = 1'b1;
          res_next.maneuver_cmd = MAN_END;
          phase_next            = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase

    res_next.phase_now = phase_num(phase_next);
    res_next.abandoned = gave_up_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_ms         <= 16'd500;
      away_angle_deg   <= 8'd45;
      return_angle_deg <= 8'd30;
      max_tries        <= 4'd3;
      diagonal_mm      <= 16'd500;
      alongside_mm     <= 16'd800;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAUSE_MS:     pause_ms         <= cfg_data;
        REG_AWAY_ANGLE:   away_angle_deg   <= cfg_data[7:0];
        REG_RETURN_ANGLE: return_angle_deg <= cfg_data[7:0];
        REG_MAX_TRIES:    max_tries        <= cfg_data[3:0];
        REG_DIAGONAL_MM:  diagonal_mm      <= cfg_data;
        REG_ALONGSIDE_MM: alongside_mm     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state advances on each accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      next_phase  <= PH_IDLE;
      pause_start <= '0;
      side_right  <= 1'b0;
      angle_sum   <= '0;
      try_count   <= '0;
      gave_up     <= 1'b0;
    end else if (s_acc) begin
      phase       <= phase_next;
      next_phase  <= next_phase_next;
      pause_start <= pause_start_next;
      side_right  <= side_right_next;
      angle_sum   <= angle_sum_next;
      try_count   <= try_count_next;
      gave_up     <= gave_up_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s_acc) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      res <= res_next;
    end
  end

  // The phase register always holds exactly one phase.
  a_phase_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(phase))
    else $error("phase register is not one-hot");

  // A reported turn angle comes only with a turn command.
  a_deg_needs_turn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.turn_cmd == TURN_NONE) |-> (res.turn_deg == 12'd0))
    else $error("turn angle without turn command");

  // Entering a pause from another phase always commands a stop.
  a_pause_halts: assert property (@(posedge clk) disable iff (rst)
    s_acc && (phase != PH_PAUSE) && (phase_next == PH_PAUSE) |=> res.halt)
    else $error("pause entered without halt");

  // The give-up latch is only set when the detour is dropped back to idle.
  a_giveup_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(gave_up) |-> (phase == PH_IDLE))
    else $error("give-up latched outside idle");

endmodule

[tb/tb_obstacle_detour_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_obstacle_detour_sequencer_core: self-checking bench for the detour core
// Ticks are fed through the input stream from a queue. Each accepted tick is
// run through a cycle-free model of the detour phases, and the command word
// it yields is compared field by field with the next word on the output
// stream. Configuration changes only happen while nothing is in flight.
// ----------------------------------------------------------------------------
module tb_obstacle_detour_sequencer_core;
  import ods_pkg::*;

  // One update tick, now_ms in the lowest bits.
  typedef struct packed {
    logic        veto;
    logic        side;
    logic        probe_busy;
    logic        motion_busy;
    logic        blocking;
    logic        autonomous;
    logic [31:0] now_ms;
  } tick_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Ticks still to send and command words still owed by the block.
  tick_t   pending_ticks[$];
  result_t expected_words[$];

  int send_idle_pct = 29;
  int recv_idle_pct = 70;
  int mismatch_count = 0;

  // Model copy of the configuration registers.
  logic [15:0] c_pause  = 16'd500;
  logic [7:0]  c_away   = 8'd45;
  logic [7:0]  c_return = 8'd30;
  logic [3:0]  c_tries  = 4'd3;
  logic [15:0] c_diag   = 16'd500;
  logic [15:0] c_along  = 16'd800;

  // Model copy of the sequencer state.
  logic [2:0]  det_phase   = PN_IDLE;
  logic [2:0]  det_next    = PN_IDLE;
  logic [31:0] pause_t0    = '0;
  logic        turn_right  = 1'b0;
  logic [11:0] angle_total = '0;
  logic [3:0]  try_num     = '0;
  logic        gave_up     = 1'b0;

  // Stimulus world for the random part.
  logic [31:0] world_ms;
  logic        obstacle_on;

  obstacle_detour_sequencer_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the detour model by one tick and return the command word.
  function automatic result_t predict_command(tick_t t);
    result_t     r;
    logic [31:0] elapsed;
    logic [12:0] sum_wide;
    logic [2:0]  pause_to;
    logic        do_pause;
    logic        do_finish;
    r = '0;
    do_pause = 1'b0;
    do_finish = 1'b0;
    pause_to = PN_IDLE;
    elapsed = t.now_ms - pause_t0;
    case (det_phase)
      PN_IDLE: begin
        if (t.autonomous && !t.blocking) begin
          gave_up = 1'b0;
        end else if (t.autonomous && !gave_up && !t.motion_busy) begin
          r.maneuver_cmd = MAN_BEGIN;
          angle_total = '0;
          try_num = '0;
          do_pause = 1'b1;
          pause_to = PN_PROBE;
        end
      end
      PN_PAUSE: begin
        if (elapsed >= {16'd0, c_pause}) begin
          det_phase = det_next;
          // Entering a step issues its command once.
          case (det_next)
            PN_PROBE: r.start_probe = 1'b1;
            PN_AWAY: begin
              r.turn_cmd = turn_right ? TURN_RIGHT : TURN_LEFT;
              r.turn_deg = {4'd0, c_away};
              sum_wide = {1'b0, angle_total} + {5'd0, c_away};
              angle_total = (sum_wide > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum_wide[11:0];
            end
            PN_DIAG: r.advance_mm = c_diag;
            PN_PTURN: begin
              r.turn_cmd = turn_right ? TURN_LEFT : TURN_RIGHT;
              r.turn_deg = angle_total;
            end
            PN_PADV: r.advance_mm = c_along;
            PN_RETURN: begin
              r.turn_cmd = turn_right ? TURN_LEFT : TURN_RIGHT;
              r.turn_deg = {4'd0, c_return};
            end
            default: ;
          endcase
        end
      end
      PN_PROBE: begin
        if (!t.probe_busy) begin
          turn_right = t.side;
          do_pause = 1'b1;
          pause_to = PN_AWAY;
        end
      end
      PN_AWAY: begin
        if (!t.motion_busy) begin
          if (!t.veto) begin
            do_pause = 1'b1;
            pause_to = PN_DIAG;
          end else begin
            // A vetoed turn is retried until the attempt budget runs out.
            try_num = try_num + 4'd1;
            if (try_num < c_tries) begin
              do_pause = 1'b1;
              pause_to = PN_AWAY;
            end else begin
              gave_up = 1'b1;
              do_finish = 1'b1;
            end
          end
        end
      end
      PN_DIAG: begin
        do_pause = !t.motion_busy;
        pause_to = PN_PTURN;
      end
      PN_PTURN: begin
        do_pause = !t.motion_busy;
        pause_to = PN_PADV;
      end
      PN_PADV: begin
        do_pause = !t.motion_busy;
        pause_to = PN_RETURN;
      end
      default: do_finish = !t.motion_busy;
    endcase
    if (do_pause) begin
      r.halt = 1'b1;
      det_next = pause_to;
      pause_t0 = t.now_ms;
      det_phase = PN_PAUSE;
    end
    if (do_finish) begin
      r.halt = 1'b1;
      r.maneuver_cmd = MAN_END;
      det_phase = PN_IDLE;
    end
    r.phase_now = det_phase;
    r.abandoned = gave_up;
    return r;
  endfunction

  function automatic tick_t make_tick(logic [31:0] now, logic autonomous, logic blocking,
                                      logic motion_busy, logic probe_busy, logic side,
                                      logic veto);
    tick_t t;
    t.now_ms = now;
    t.autonomous = autonomous;
    t.blocking = blocking;
    t.motion_busy = motion_busy;
    t.probe_busy = probe_busy;
    t.side = side;
    t.veto = veto;
    return t;
  endfunction

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatch_count++;
    end
  endtask

  // One register write; the model copy is updated at once, when the write is driven.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_PAUSE_MS:     c_pause = val;
      REG_AWAY_ANGLE:   c_away = val[7:0];
      REG_RETURN_ANGLE: c_return = val[7:0];
      REG_MAX_TRIES:    c_tries = val[3:0];
      REG_DIAGONAL_MM:  c_diag = val;
      REG_ALONGSIDE_MM: c_along = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [15:0] pause, input logic [7:0] away,
                                input logic [7:0] ret, input logic [3:0] tries,
                                input logic [15:0] diag, input logic [15:0] along);
    write_reg(REG_PAUSE_MS, pause);
    write_reg(REG_AWAY_ANGLE, {8'd0, away});
    write_reg(REG_RETURN_ANGLE, {8'd0, ret});
    write_reg(REG_MAX_TRIES, {12'd0, tries});
    write_reg(REG_DIAGONAL_MM, diag);
    write_reg(REG_ALONGSIDE_MM, along);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every tick is sent and every command word has come back.
  task automatic wait_drained();
    while (pending_ticks.size() != 0 || expected_words.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Random ticks: time mostly creeps forward, sometimes jumps past the pause,
  // and now and then lands anywhere. The obstacle comes and goes in runs.
  task automatic queue_random_ticks(input int count);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 70)
        world_ms += $urandom_range(20);
      else if (roll < 90)
        world_ms += $urandom_range(int'(c_pause) * 2 + 1);
      else
        world_ms = $urandom;
      if ($urandom_range(99) < 6)
        obstacle_on = !obstacle_on;
      pending_ticks.push_back(make_tick(world_ms, $urandom_range(99) < 85, obstacle_on,
                                        $urandom_range(99) < 35, $urandom_range(99) < 40,
                                        1'($urandom_range(1)), $urandom_range(99) < 35));
    end
  endtask

  // Driver: present the next tick once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_words.push_back(predict_command(tick_t'(s_tdata[37:0])));
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata <= {2'b00, pending_ticks.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and field-by-field comparison.
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("command word arrived with none expected");
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          got = result_t'(m_tdata[37:0]);
          check_field("halt", 32'(want.halt), 32'(got.halt));
          check_field("maneuver_cmd", 32'(want.maneuver_cmd), 32'(got.maneuver_cmd));
          check_field("start_probe", 32'(want.start_probe), 32'(got.start_probe));
          check_field("turn_cmd", 32'(want.turn_cmd), 32'(got.turn_cmd));
          check_field("turn_deg", 32'(want.turn_deg), 32'(got.turn_deg));
          check_field("advance_mm", 32'(want.advance_mm), 32'(got.advance_mm));
          check_field("phase_now", 32'(want.phase_now), 32'(got.phase_now));
          check_field("abandoned", 32'(want.abandoned), 32'(got.abandoned));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    logic [31:0] t0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Full detour at reset settings, with the pause timer wrapping past zero.
    t0 = 32'hFFFF_FF00;
    pending_ticks.push_back(make_tick(t0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));    // not autonomous
    pending_ticks.push_back(make_tick(t0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));    // still moving
    pending_ticks.push_back(make_tick(t0 + 1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // detour begins
    pending_ticks.push_back(make_tick(t0 + 500, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // one ms short
    pending_ticks.push_back(make_tick(t0 + 501, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)); // probe, mode ignored
    pending_ticks.push_back(make_tick(t0 + 502, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0)); // probe running
    pending_ticks.push_back(make_tick(t0 + 503, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0)); // right is clearer
    pending_ticks.push_back(make_tick(t0 + 1003, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1)); // turn away
    pending_ticks.push_back(make_tick(t0 + 1004, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1)); // turn running
    pending_ticks.push_back(make_tick(t0 + 1005, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1)); // vetoed, retry
    pending_ticks.push_back(make_tick(t0 + 1505, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1)); // second turn away
    pending_ticks.push_back(make_tick(t0 + 1506, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // veto gone
    pending_ticks.push_back(make_tick(t0 + 2006, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // diagonal
    pending_ticks.push_back(make_tick(t0 + 2007, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(t0 + 2008, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(t0 + 2508, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // parallel turn
    pending_ticks.push_back(make_tick(t0 + 2509, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(t0 + 3009, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // parallel advance
    pending_ticks.push_back(make_tick(t0 + 3010, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(t0 + 3510, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // return turn
    pending_ticks.push_back(make_tick(t0 + 3511, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    pending_ticks.push_back(make_tick(t0 + 3512, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // detour ends
    wait_drained();

    // No pause, zero turn angle, no retries allowed, writes to unused indexes.
    write_reg(REG_PAUSE_MS, 16'd0);
    write_reg(REG_AWAY_ANGLE, 16'd0);
    write_reg(REG_MAX_TRIES, 16'd0);
    write_reg(3'd6, 16'hFFFF);
    write_reg(3'd7, 16'h5A5A);
    @(posedge clk);
    cfg_we <= 1'b0;
    pending_ticks.push_back(make_tick(32'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // detour begins
    pending_ticks.push_back(make_tick(32'd100, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)); // expires at once
    pending_ticks.push_back(make_tick(32'd101, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1)); // left is clearer
    pending_ticks.push_back(make_tick(32'd101, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1)); // zero-degree turn
    pending_ticks.push_back(make_tick(32'd102, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1)); // first veto gives up
    pending_ticks.push_back(make_tick(32'd103, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // latched, no restart
    pending_ticks.push_back(make_tick(32'd104, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)); // obstacle gone
    pending_ticks.push_back(make_tick(32'd105, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)); // starts again
    wait_drained();

    // Random phases under changing settings and flow-control patterns.
    world_ms = $urandom;
    obstacle_on = 1'b1;
    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 29 : (p < 4) ? 70 : 0;
      recv_idle_pct = (p < 2) ? 70 : (p < 4) ? 29 : 0;
      case (p)
        0: write_all_regs(16'hFFFF, 8'd255, 8'd255, 4'd15, 16'hFFFF, 16'hFFFF);
        1: write_all_regs(16'd0, 8'd1, 8'd1, 4'd1, 16'd0, 16'd0);
        default: write_all_regs(16'($urandom_range(40)), 8'($urandom_range(1, 180)),
                                8'($urandom_range(1, 180)), 4'($urandom_range(1, 15)),
                                16'($urandom_range(16'hFFFF)),
                                16'($urandom_range(16'hFFFF)));
      endcase
      queue_random_ticks(312);
      wait_drained();
    end

    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
design/ods_pkg.sv
design/obstacle_detour_sequencer_core.sv
tb/tb_obstacle_detour_sequencer_core.sv
